// ===== src/stereo_upmix_with_compressor_defines.svh =====
// Assertion macros for the stereo upmix with compressor block.
// Used by the top level; no other dependencies.
`ifndef STEREO_UPMIX_WITH_COMPRESSOR_DEFINES_SVH
`define STEREO_UPMIX_WITH_COMPRESSOR_DEFINES_SVH
`ifndef SYNTHESIS
`define SUMX_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SUMX_ASSERT_NR(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SUMX_ASSERT(name, clk, rst, prop, msg)
`define SUMX_ASSERT_NR(name, clk, prop, msg)
`endif
`endif

// ===== src/sumx_pkg.sv =====
// Shared types and constants of the stereo upmix with compressor block.
// No dependencies.
package sumx_pkg;

   // Register widths and fixed-point positions.
   localparam int GAIN_W     = 23;
   localparam int RATIO_W    = 21;
   localparam int GAIN_SHIFT = 20;
   localparam int THR_FRAC   = 23;
   localparam logic [RATIO_W-1:0] RATIO_ONE = 21'd1048576;

   // Register indexes on the configuration port.
   typedef enum logic [2:0] {
      CSR_PRE_GAIN      = 3'd0,
      CSR_MODE_SELECT   = 3'd1,
      CSR_SURROUND_ZERO = 3'd2,
      CSR_SURROUND_ONE  = 3'd3,
      CSR_EFFECT_ZERO   = 3'd4,
      CSR_EFFECT_ONE    = 3'd5,
      CSR_THRESHOLD     = 3'd6,
      CSR_RATIO         = 3'd7
   } csr_index_type;

   // Reset values of the registers.
   localparam logic [GAIN_W-1:0]  RST_PRE_GAIN      = 23'd525537;
   localparam logic               RST_MODE_SELECT   = 1'b0;
   localparam logic [GAIN_W-1:0]  RST_SURROUND_ZERO = 23'd166189;
   localparam logic [GAIN_W-1:0]  RST_SURROUND_ONE  = 23'd525537;
   localparam logic [GAIN_W-1:0]  RST_EFFECT_ZERO   = 23'd1864662;
   localparam logic [GAIN_W-1:0]  RST_EFFECT_ONE    = 23'd1481154;
   localparam logic [GAIN_W-1:0]  RST_THRESHOLD     = 23'd2516582;
   localparam logic [RATIO_W-1:0] RST_RATIO         = 21'd52429;

endpackage

// ===== src/sumx_gain.sv =====
// Input register and input gain stage of the stereo upmix block.
// Depends on sumx_pkg.
module sumx_gain #(
   parameter int SB = 24
) (
   input  logic                           clock,
   input  logic [1:0]                     en,
   input  logic signed [SB-1:0]           left_in,
   input  logic signed [SB-1:0]           right_in,
   input  logic [sumx_pkg::GAIN_W-1:0]    pre_gain,
   output logic signed [SB+2:0]           left_gained,
   output logic signed [SB+2:0]           right_gained
);
   import sumx_pkg::*;

   localparam int MW = SB + 2;
   localparam int LW = SB + 3;
   localparam int PW = SB + GAIN_W;

   logic signed [SB-1:0] xl_ff, xr_ff;
   logic [SB-1:0]        ml, mr;
   logic [PW-1:0]        pl, pr;
   logic signed [LW-1:0] l_in, r_in, l_ff, r_ff;

   // Stage 0: capture the input item.
   always_ff @(posedge clock) begin
      if (en[0]) begin
         xl_ff <= left_in;
         xr_ff <= right_in;
      end
   end

   // Stage 1: magnitude times gain, truncated, sign restored.
   always_comb begin
      ml = xl_ff[SB-1] ? SB'(-xl_ff) : SB'(xl_ff);
      mr = xr_ff[SB-1] ? SB'(-xr_ff) : SB'(xr_ff);
      pl = PW'(ml) * PW'(pre_gain);
      pr = PW'(mr) * PW'(pre_gain);
      l_in = xl_ff[SB-1] ? -$signed({1'b0, pl[MW+GAIN_SHIFT-1:GAIN_SHIFT]})
                         :  $signed({1'b0, pl[MW+GAIN_SHIFT-1:GAIN_SHIFT]});
      r_in = xr_ff[SB-1] ? -$signed({1'b0, pr[MW+GAIN_SHIFT-1:GAIN_SHIFT]})
                         :  $signed({1'b0, pr[MW+GAIN_SHIFT-1:GAIN_SHIFT]});
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         l_ff <= l_in;
         r_ff <= r_in;
      end
   end

   assign left_gained  = l_ff;
   assign right_gained = r_ff;
endmodule

// ===== src/sumx_comp.sv =====
// Dynamic range compressor, hard or soft knee, as a pipeline.
// Depends on sumx_pkg. The soft knee has a one-bit-per-stage divider.
module sumx_comp #(
   parameter int SB        = 24,
   parameter int SOFT_KNEE = 0,
   parameter int CL        = 2
) (
   input  logic                          clock,
   input  logic [CL-1:0]                 en,
   input  logic signed [SB+2:0]          left_gained,
   input  logic [sumx_pkg::GAIN_W-1:0]   threshold,
   input  logic [sumx_pkg::RATIO_W-1:0]  ratio,
   output logic signed [SB+2:0]          compressed
);
   import sumx_pkg::*;

   localparam int F  = SB - 1;
   localparam int MW = SB + 2;
   localparam int LW = SB + 3;

   logic [SB-1:0]      t;
   logic [MW-1:0]      tm, m_in;
   logic [RATIO_W-1:0] rc;

   // Threshold brought to F fraction bits; ratio clamped to one.
   generate
      if (F >= THR_FRAC) begin : g_thr_up
         assign t = SB'(threshold) << (F - THR_FRAC);
      end else begin : g_thr_dn
         assign t = SB'(threshold >> (THR_FRAC - F));
      end
   endgenerate
   assign tm   = MW'(t);
   assign rc   = (ratio > RATIO_ONE) ? RATIO_ONE : ratio;
   assign m_in = left_gained[LW-1] ? MW'(-left_gained) : MW'(left_gained);

   generate
      if (SOFT_KNEE == 0) begin : g_hard
         logic [MW-1:0]         m_ff, diff_ff, yh, y;
         logic                  neg_ff, over_ff;
         logic [MW+RATIO_W-1:0] p;
         logic signed [LW-1:0]  y_ff;

         // First stage: compare against the threshold.
         always_ff @(posedge clock) begin
            if (en[0]) begin
               m_ff    <= m_in;
               neg_ff  <= left_gained[LW-1];
               over_ff <= m_in > tm;
               diff_ff <= m_in - tm;
            end
         end

         // Second stage: scale the excess by the ratio.
         always_comb begin
            p  = (MW+RATIO_W)'(diff_ff) * (MW+RATIO_W)'(rc);
            yh = tm + p[MW+GAIN_SHIFT-1:GAIN_SHIFT];
            y  = over_ff ? yh : m_ff;
         end

         always_ff @(posedge clock) begin
            if (en[1]) begin
               y_ff <= neg_ff ? -$signed({1'b0, y}) : $signed({1'b0, y});
            end
         end
         assign compressed = y_ff;
      end else begin : g_soft
         localparam int RW = 2 * F + 2;
         localparam logic [MW-1:0] ONE_M = MW'(1) << F;

         logic [MW-1:0]  m1_ff, diffb1_ff;
         logic [F:0]     diffm1_ff;
         logic [F+1:0]   den1_ff;
         logic           neg1_ff, big1_ff, mid1_ff;
         logic [F:0]     omt;

         logic [MW-1:0]  m_ff     [F+1];
         logic [MW-1:0]  diffb_ff [F+1];
         logic [F+1:0]   den_ff   [F+1];
         logic [RW-1:0]  rem_ff   [F+1];
         logic [F-1:0]   q_ff     [F+1];
         logic           neg_ff   [F+1];
         logic           big_ff   [F+1];
         logic           mid_ff   [F+1];

         logic [F+RATIO_W-1:0]  pq;
         logic [MW+RATIO_W-1:0] pb;
         logic [RATIO_W-1:0]    omr;
         logic [MW-1:0]         yq, yb, y;
         logic signed [LW-1:0]  y_ff;

         assign omt = (F+1)'(ONE_M) - t;

         // First stage: knee region and operands of the quadratic.
         always_ff @(posedge clock) begin
            if (en[0]) begin
               m1_ff     <= m_in;
               neg1_ff   <= left_gained[LW-1];
               big1_ff   <= m_in > ONE_M;
               mid1_ff   <= m_in > tm;
               diffb1_ff <= m_in - ONE_M;
               diffm1_ff <= (F+1)'(m_in - tm);
               den1_ff   <= {omt, 1'b0};
            end
         end

         // Second stage: square of the distance above the threshold.
         always_ff @(posedge clock) begin
            if (en[1]) begin
               m_ff[0]     <= m1_ff;
               neg_ff[0]   <= neg1_ff;
               big_ff[0]   <= big1_ff;
               mid_ff[0]   <= mid1_ff;
               diffb_ff[0] <= diffb1_ff;
               den_ff[0]   <= den1_ff;
               rem_ff[0]   <= RW'(diffm1_ff) * RW'(diffm1_ff);
               q_ff[0]     <= '0;
            end
         end

         // Divider: one quotient bit per stage, most significant first.
         for (genvar j = 1; j <= F; j++) begin : g_div
            logic [RW-1:0] trial;
            assign trial = RW'(den_ff[j-1]) << (F - j);
            always_ff @(posedge clock) begin
               if (en[j+1]) begin
                  m_ff[j]     <= m_ff[j-1];
                  neg_ff[j]   <= neg_ff[j-1];
                  big_ff[j]   <= big_ff[j-1];
                  mid_ff[j]   <= mid_ff[j-1];
                  diffb_ff[j] <= diffb_ff[j-1];
                  den_ff[j]   <= den_ff[j-1];
                  if (rem_ff[j-1] >= trial) begin
                     rem_ff[j]       <= rem_ff[j-1] - trial;
                     q_ff[j]         <= q_ff[j-1] | (F'(1) << (F - j));
                  end else begin
                     rem_ff[j]       <= rem_ff[j-1];
                     q_ff[j]         <= q_ff[j-1];
                  end
               end
            end
         end

         // Last stage: apply the linear slope above one, the quadratic above the threshold, else pass the magnitude.
         always_comb begin
            omr = RATIO_ONE - rc;
            pq  = (F+RATIO_W)'(q_ff[F]) * (F+RATIO_W)'(omr);
            pb  = (MW+RATIO_W)'(diffb_ff[F]) * (MW+RATIO_W)'(rc);
            yq  = m_ff[F] - MW'(pq[F+RATIO_W-1:GAIN_SHIFT]);
            yb  = ONE_M + pb[MW+GAIN_SHIFT-1:GAIN_SHIFT];
            if (big_ff[F]) begin
               y = yb;
            end else if (mid_ff[F]) begin
               y = yq;
            end else begin
               y = m_ff[F];
            end
         end

         always_ff @(posedge clock) begin
            if (en[F+2]) begin
               y_ff <= neg_ff[F] ? -$signed({1'b0, y}) : $signed({1'b0, y});
            end
         end
         assign compressed = y_ff;
      end
   endgenerate
endmodule

// ===== src/sumx_mix.sv =====
// Surround and effect gains, output sums and saturation.
// Depends on sumx_pkg; runs alongside the compressor pipeline.
module sumx_mix #(
   parameter int SB = 24,
   parameter int CL = 2
) (
   input  logic                         clock,
   input  logic [CL+1:0]                en,
   input  logic signed [SB+2:0]         left_gained,
   input  logic signed [SB+2:0]         right_gained,
   input  logic signed [SB+2:0]         compressed,
   input  logic [sumx_pkg::GAIN_W-1:0]  surround_gain,
   input  logic [sumx_pkg::GAIN_W-1:0]  effect_gain,
   output logic signed [SB-1:0]         front_left,
   output logic signed [SB-1:0]         front_right,
   output logic signed [SB-1:0]         surround_left,
   output logic signed [SB-1:0]         surround_right,
   output logic signed [SB-1:0]         effect_out
);
   import sumx_pkg::*;

   localparam int MW = SB + 2;
   localparam int LW = SB + 3;
   localparam int SW = SB + 6;
   localparam int TW = SB + 8;
   localparam int PW = MW + GAIN_W;
   localparam logic signed [TW-1:0] HI = (TW'(1) <<< (SB - 1)) - TW'(1);
   localparam logic signed [TW-1:0] LO = -HI - TW'(1);

   logic signed [LW-1:0] l_ff [CL];
   logic signed [LW-1:0] r_ff [CL];
   logic signed [SW-1:0] s_ff [CL];
   logic signed [LW-1:0] l2_ff, r2_ff;
   logic signed [SW-1:0] s2_ff, e2_ff;

   logic [MW-1:0]        lm, ym;
   logic [PW-1:0]        ps, pe;
   logic signed [SW-1:0] s_in, e_in;
   logic signed [TW-1:0] sum_fl, ext_r, neg_r, ext_s, ext_e;
   logic signed [SB-1:0] fl_ff, fr_ff, sl_ff, sr_ff, eo_ff;

   function automatic logic signed [SB-1:0] sat(input logic signed [TW-1:0] v);
      if (v > HI) begin
         sat = SB'(HI);
      end else if (v < LO) begin
         sat = SB'(LO);
      end else begin
         sat = SB'(v);
      end
   endfunction

   // Surround product, then delay to line up with the compressor.
   always_comb begin
      lm   = left_gained[LW-1] ? MW'(-left_gained) : MW'(left_gained);
      ps   = PW'(lm) * PW'(surround_gain);
      s_in = left_gained[LW-1] ? -$signed({1'b0, ps[PW-1:GAIN_SHIFT]})
                               :  $signed({1'b0, ps[PW-1:GAIN_SHIFT]});
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         l_ff[0] <= left_gained;
         r_ff[0] <= right_gained;
         s_ff[0] <= s_in;
      end
   end

   for (genvar k = 1; k < CL; k++) begin : g_dly
      always_ff @(posedge clock) begin
         if (en[k]) begin
            l_ff[k] <= l_ff[k-1];
            r_ff[k] <= r_ff[k-1];
            s_ff[k] <= s_ff[k-1];
         end
      end
   end

   // Effect product on the compressed left.
   always_comb begin
      ym   = compressed[LW-1] ? MW'(-compressed) : MW'(compressed);
      pe   = PW'(ym) * PW'(effect_gain);
      e_in = compressed[LW-1] ? -$signed({1'b0, pe[PW-1:GAIN_SHIFT]})
                              :  $signed({1'b0, pe[PW-1:GAIN_SHIFT]});
   end

   always_ff @(posedge clock) begin
      if (en[CL]) begin
         l2_ff <= l_ff[CL-1];
         r2_ff <= r_ff[CL-1];
         s2_ff <= s_ff[CL-1];
         e2_ff <= e_in;
      end
   end

   // Output sums and saturation into the output register.
   always_comb begin
      ext_s  = TW'(s2_ff);
      ext_e  = TW'(e2_ff);
      ext_r  = TW'(r2_ff);
      neg_r  = -ext_r;
      sum_fl = ext_s + TW'(l2_ff) + ext_e;
   end

   always_ff @(posedge clock) begin
      if (en[CL+1]) begin
         fl_ff <= sat(sum_fl);
         fr_ff <= sat(ext_r);
         sl_ff <= sat(ext_s);
         sr_ff <= sat(neg_r);
         eo_ff <= sat(ext_e);
      end
   end

   assign front_left     = fl_ff;
   assign front_right    = fr_ff;
   assign surround_left  = sl_ff;
   assign surround_right = sr_ff;
   assign effect_out     = eo_ff;
endmodule

// ===== src/stereo_upmix_with_compressor.sv =====
// Stereo upmix with compressor, top level: registers, pipeline control.
// Depends on sumx_pkg, sumx_gain, sumx_comp, sumx_mix and the defines header.
// Six register stages with the hard knee; with the soft knee, the compressor has a
// divider that takes one stage per quotient bit. Throughput: one item per cycle
// while the result side takes results; rsp_ready low stalls the pipeline.
// Reset (synchronous) clears all valid bits and loads register defaults.
`include "stereo_upmix_with_compressor_defines.svh"
module stereo_upmix_with_compressor #(
   parameter int SOFT_KNEE   = 0,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_left_sample,
   input  logic signed [SAMPLE_BITS-1:0] req_right_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_front_left,
   output logic signed [SAMPLE_BITS-1:0] rsp_front_right,
   output logic signed [SAMPLE_BITS-1:0] rsp_surround_left,
   output logic signed [SAMPLE_BITS-1:0] rsp_surround_right,
   output logic signed [SAMPLE_BITS-1:0] rsp_effect_out,
   input  logic                          csr_write_en,
   input  logic [2:0]                    csr_index,
   input  logic [sumx_pkg::GAIN_W-1:0]   csr_wdata
);
   import sumx_pkg::*;

   localparam int SB = SAMPLE_BITS;
   localparam int CL = (SOFT_KNEE != 0) ? SB + 2 : 2;
   localparam int N  = CL + 4;

   logic [GAIN_W-1:0]  pre_gain_ff, sg0_ff, sg1_ff, eg0_ff, eg1_ff, thr_ff;
   logic [RATIO_W-1:0] ratio_ff;
   logic               mode_ff;
   logic [GAIN_W-1:0]  sg, eg;

   logic [N-1:0] vld_ff, vld_in, en;
   logic signed [SB+2:0] l_g, r_g, y_c;

   logic out_stall, fr_mid, mirror_ok;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pre_gain_ff <= RST_PRE_GAIN;
         mode_ff     <= RST_MODE_SELECT;
         sg0_ff      <= RST_SURROUND_ZERO;
         sg1_ff      <= RST_SURROUND_ONE;
         eg0_ff      <= RST_EFFECT_ZERO;
         eg1_ff      <= RST_EFFECT_ONE;
         thr_ff      <= RST_THRESHOLD;
         ratio_ff    <= RST_RATIO;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_PRE_GAIN:      pre_gain_ff <= csr_wdata;
            CSR_MODE_SELECT:   mode_ff     <= csr_wdata[0];
            CSR_SURROUND_ZERO: sg0_ff      <= csr_wdata;
            CSR_SURROUND_ONE:  sg1_ff      <= csr_wdata;
            CSR_EFFECT_ZERO:   eg0_ff      <= csr_wdata;
            CSR_EFFECT_ONE:    eg1_ff      <= csr_wdata;
            CSR_THRESHOLD:     thr_ff      <= csr_wdata;
            CSR_RATIO:         ratio_ff    <= csr_wdata[RATIO_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign sg = mode_ff ? sg1_ff : sg0_ff;
   assign eg = mode_ff ? eg1_ff : eg0_ff;

   // Stage enables: a stage moves when it is empty or its successor moves.
   always_comb begin
      en[N-1] = !vld_ff[N-1] || rsp_ready;
      for (int k = N - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
      vld_in = vld_ff;
      for (int k = 0; k < N; k++) begin
         if (en[k]) begin
            vld_in[k] = (k == 0) ? req_valid : vld_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = vld_ff[N-1];

   sumx_gain #(.SB(SB)) u_gain (
      .clock        (clock),
      .en           (en[1:0]),
      .left_in      (req_left_sample),
      .right_in     (req_right_sample),
      .pre_gain     (pre_gain_ff),
      .left_gained  (l_g),
      .right_gained (r_g)
   );

   sumx_comp #(.SB(SB), .SOFT_KNEE(SOFT_KNEE), .CL(CL)) u_comp (
      .clock       (clock),
      .en          (en[CL+1:2]),
      .left_gained (l_g),
      .threshold   (thr_ff),
      .ratio       (ratio_ff),
      .compressed  (y_c)
   );

   sumx_mix #(.SB(SB), .CL(CL)) u_mix (
      .clock          (clock),
      .en             (en[CL+3:2]),
      .left_gained    (l_g),
      .right_gained   (r_g),
      .compressed     (y_c),
      .surround_gain  (sg),
      .effect_gain    (eg),
      .front_left     (rsp_front_left),
      .front_right    (rsp_front_right),
      .surround_left  (rsp_surround_left),
      .surround_right (rsp_surround_right),
      .effect_out     (rsp_effect_out)
   );

   // Terms for the checks below; front right is away from the limits when
   // its two top bits agree.
   assign out_stall = rsp_valid && !rsp_ready;
   assign fr_mid    = rsp_valid && (rsp_front_right[SB-1] == rsp_front_right[SB-2]);
   assign mirror_ok = (rsp_surround_right + rsp_front_right) == '0;

   // The input side only stalls when the output holds an untaken item.
   `SUMX_ASSERT(a_in_stall, clock, reset, !req_ready |-> out_stall, "input stalled alone")
   // Valid bits are clear right after reset.
   `SUMX_ASSERT_NR(a_reset_clears, clock, $past(reset) |-> !rsp_valid, "result valid after reset")
   // Surround right mirrors front right away from the saturation limits.
   `SUMX_ASSERT(a_right_mirror, clock, reset, fr_mid |-> mirror_ok, "surround right not mirrored")
endmodule

// ===== dv/sumx_checker.sv =====
// Checker for the stereo upmix with compressor: predicts each result item from
// accepted input items and the shadow registers, and compares. Depends on sumx_pkg.
module sumx_checker #(
   parameter int SOFT_KNEE   = 0,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_left_sample,
   input  logic signed [SAMPLE_BITS-1:0] req_right_sample,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic signed [SAMPLE_BITS-1:0] rsp_front_left,
   input  logic signed [SAMPLE_BITS-1:0] rsp_front_right,
   input  logic signed [SAMPLE_BITS-1:0] rsp_surround_left,
   input  logic signed [SAMPLE_BITS-1:0] rsp_surround_right,
   input  logic signed [SAMPLE_BITS-1:0] rsp_effect_out,
   input  logic                          csr_write_en,
   input  logic [2:0]                    csr_index,
   input  logic [sumx_pkg::GAIN_W-1:0]   csr_wdata,
   output int                            error_count,
   output int                            pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import sumx_pkg::*;

   localparam int FRAC = SAMPLE_BITS - 1;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] front_left;
      logic signed [SAMPLE_BITS-1:0] front_right;
      logic signed [SAMPLE_BITS-1:0] surround_left;
      logic signed [SAMPLE_BITS-1:0] surround_right;
      logic signed [SAMPLE_BITS-1:0] effect_out;
   } upmix_frame_type;

   upmix_frame_type frames_due[$];

   // Shadow copy of the configuration registers.
   logic [GAIN_W-1:0]  sh_pre_gain, sh_surround_zero, sh_surround_one;
   logic [GAIN_W-1:0]  sh_effect_zero, sh_effect_one, sh_threshold;
   logic [RATIO_W-1:0] sh_ratio;
   logic               sh_mode;

   // Product by a Q3.20 gain, rounded toward zero.
   function automatic longint scale_q20(longint v, longint g);
      longint mag;
      mag = (v < 0) ? -v : v;
      mag = (mag * g) >>> GAIN_SHIFT;
      return (v < 0) ? -mag : mag;
   endfunction

   function automatic longint clip_sample(longint v);
      longint hi;
      hi = (longint'(1) <<< FRAC) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   // Odd-symmetric compressor on the magnitude of the gained left sample.
   function automatic longint compress_left(longint x);
      longint r, t, one, mag, y, d, q;
      r = (sh_ratio > RATIO_ONE) ? longint'(RATIO_ONE) : longint'(sh_ratio);
      t = (FRAC >= THR_FRAC) ? (longint'(sh_threshold) <<< (FRAC - THR_FRAC))
                             : (longint'(sh_threshold) >>> (THR_FRAC - FRAC));
      one = longint'(1) <<< FRAC;
      mag = (x < 0) ? -x : x;
      y = mag;
      if (SOFT_KNEE == 0) begin
         if (mag > t) y = t + (((mag - t) * r) >>> GAIN_SHIFT);
      end else if (mag > one) begin
         y = one + (((mag - one) * r) >>> GAIN_SHIFT);
      end else if (mag > t) begin
         d = mag - t;
         q = (d * d) / (2 * (one - t));
         y = mag - ((q * (longint'(RATIO_ONE) - r)) >>> GAIN_SHIFT);
      end
      return (x < 0) ? -y : y;
   endfunction

   function automatic upmix_frame_type predict_upmix(longint left, longint right);
      upmix_frame_type f;
      longint l, r, s, e;
      l = scale_q20(left, sh_pre_gain);
      r = scale_q20(right, sh_pre_gain);
      s = scale_q20(l, sh_mode ? sh_surround_one : sh_surround_zero);
      e = scale_q20(compress_left(l), sh_mode ? sh_effect_one : sh_effect_zero);
      f.front_left     = SAMPLE_BITS'(clip_sample(s + l + e));
      f.front_right    = SAMPLE_BITS'(clip_sample(r));
      f.surround_left  = SAMPLE_BITS'(clip_sample(s));
      f.surround_right = SAMPLE_BITS'(clip_sample(-r));
      f.effect_out     = SAMPLE_BITS'(clip_sample(e));
      return f;
   endfunction

   task automatic compare_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   assign pending_count = frames_due.size();

   // Register writes, input items and result items, all sampled at the edge.
   always @(posedge clock) begin
      upmix_frame_type want;
      if (reset) begin
         sh_pre_gain      <= RST_PRE_GAIN;
         sh_mode          <= RST_MODE_SELECT;
         sh_surround_zero <= RST_SURROUND_ZERO;
         sh_surround_one  <= RST_SURROUND_ONE;
         sh_effect_zero   <= RST_EFFECT_ZERO;
         sh_effect_one    <= RST_EFFECT_ONE;
         sh_threshold     <= RST_THRESHOLD;
         sh_ratio         <= RST_RATIO;
         frames_due.delete();
         error_count = 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index_type'(csr_index))
               CSR_PRE_GAIN:      sh_pre_gain      <= csr_wdata;
               CSR_MODE_SELECT:   sh_mode          <= csr_wdata[0];
               CSR_SURROUND_ZERO: sh_surround_zero <= csr_wdata;
               CSR_SURROUND_ONE:  sh_surround_one  <= csr_wdata;
               CSR_EFFECT_ZERO:   sh_effect_zero   <= csr_wdata;
               CSR_EFFECT_ONE:    sh_effect_one    <= csr_wdata;
               CSR_THRESHOLD:     sh_threshold     <= csr_wdata;
               CSR_RATIO:         sh_ratio         <= csr_wdata[RATIO_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            frames_due.push_back(predict_upmix(req_left_sample, req_right_sample));
         if (rsp_valid && rsp_ready) begin
            if (frames_due.size() == 0) begin
               $error("result item with no expectation waiting");
               error_count++;
            end else begin
               want = frames_due.pop_front();
               compare_field("front_left", want.front_left, rsp_front_left);
               compare_field("front_right", want.front_right, rsp_front_right);
               compare_field("surround_left", want.surround_left, rsp_surround_left);
               compare_field("surround_right", want.surround_right, rsp_surround_right);
               compare_field("effect_out", want.effect_out, rsp_effect_out);
            end
         end
      end
   end

endmodule

// ===== dv/stereo_upmix_with_compressor_tb.sv =====
// Testbench top for the stereo upmix with compressor: clock, reset, register
// phases and sample stimulus. Depends on sumx_pkg, the block and sumx_checker.
module stereo_upmix_with_compressor_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sumx_pkg::*;

   localparam int  SB         = 24;
   localparam int  LAT        = 40;
   localparam int  CYCLE_CAP  = 400000;
   localparam logic signed [SB-1:0] S_MAX = 24'sh7FFFFF;
   localparam logic signed [SB-1:0] S_MIN = 24'sh800000;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   logic signed [SB-1:0] req_left_sample, req_right_sample;
   logic signed [SB-1:0] rsp_front_left, rsp_front_right, rsp_surround_left;
   logic signed [SB-1:0] rsp_surround_right, rsp_effect_out;
   logic csr_write_en;
   logic [2:0] csr_index;
   logic [GAIN_W-1:0] csr_wdata;
   int error_count, pending_count;
   int cycle_count = 0;
   bit calm_tail;

   stereo_upmix_with_compressor i_dut (.*);

   sumx_checker #(.SAMPLE_BITS(SB)) i_checker (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // Run timeout.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("stereo_upmix_with_compressor verification failed");
         $finish;
      end
   end

   // Result side back-pressure, in bursts, none in the calm tail.
   initial begin
      rsp_ready = 1;
      forever begin
         @(posedge clock);
         if (!calm_tail && $urandom_range(0, 9) == 0) begin
            rsp_ready <= 0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_ready <= 1;
         end
      end
   end

   // One register write, followed by a cycle with the write enable low.
   task automatic write_reg(csr_index_type idx, logic [GAIN_W-1:0] val);
      csr_write_en <= 1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 0;
      @(posedge clock);
   endtask

   // Drive one sample pair and hold it until accepted; optional sender gap.
   task automatic send_pair(logic signed [SB-1:0] left, logic signed [SB-1:0] right);
      if (!calm_tail && $urandom_range(0, 9) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid        <= 1;
      req_left_sample  <= left;
      req_right_sample <= right;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop sending and wait until every expected result item has come.
   task automatic drain;
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (LAT) @(posedge clock);
   endtask

   // Random sample, often near full scale or small to reach every knee region.
   function automatic logic signed [SB-1:0] pick_sample();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? S_MAX - $urandom_range(0, 255)
                                        : S_MIN + $urandom_range(0, 255);
         2: return $signed(SB'($urandom_range(0, 4095))) - 2048;
         default: return $signed(SB'($urandom)) >>> $urandom_range(0, 8);
      endcase
   endfunction

   task automatic random_regs(bit extreme);
      for (int i = 0; i < 8; i++) begin
         logic [GAIN_W-1:0] v;
         v = extreme ? ($urandom_range(0, 1) ? '1 : '0) : $urandom;
         if (csr_index_type'(i) == CSR_RATIO && !extreme)
            v = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1048576);
         write_reg(csr_index_type'(i), v);
      end
   endtask

   initial begin
      logic signed [SB-1:0] corners[8];
      req_valid = 0;
      req_left_sample = 0;
      req_right_sample = 0;
      csr_write_en = 0;
      csr_index = CSR_PRE_GAIN;
      csr_wdata = 0;
      calm_tail = 0;
      reset = 1;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: full-scale corners and knee edges under reset settings.
      corners = '{S_MAX, S_MIN, 0, -1, 1, 24'sd2516582, -24'sd2516583, 24'sd4194304};
      foreach (corners[i]) send_pair(corners[i], corners[7 - i]);
      drain();

      // Zero threshold, ratio above one, mode one, large gains.
      write_reg(CSR_THRESHOLD, 0);
      write_reg(CSR_RATIO, 23'h1FFFFF);
      write_reg(CSR_MODE_SELECT, 1);
      write_reg(CSR_PRE_GAIN, 23'h7FFFFF);
      foreach (corners[i]) send_pair(corners[i], corners[i]);
      drain();
      write_reg(CSR_RATIO, 0);
      write_reg(CSR_THRESHOLD, 23'h7FFFFF);
      write_reg(CSR_PRE_GAIN, 1048576);
      foreach (corners[i]) send_pair(corners[i], -corners[i]);
      drain();

      // Random phases with fresh settings; the first two use extremes.
      for (int ph = 0; ph < 14; ph++) begin
         random_regs(ph < 2);
         if (ph == 13) calm_tail = 1;
         repeat (100) send_pair(pick_sample(), pick_sample());
         drain();
      end

      if (error_count == 0)
         $display("stereo_upmix_with_compressor verification clean");
      else
         $display("stereo_upmix_with_compressor verification failed");
      $finish;
   end

endmodule
